// ----- design/separable_gaussian_blur_assert.svh -----
// Assertion macros used by the separable Gaussian blur top level.
`ifndef SEPARABLE_GAUSSIAN_BLUR_ASSERT_SVH
`define SEPARABLE_GAUSSIAN_BLUR_ASSERT_SVH

`ifndef SYNTHESIS
`define SGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SGB_ASSERT(lbl, prop, msg)
`define SGB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- design/sgb_pkg.sv -----
// Package with the constants, types and weight table of the separable Gaussian blur.
`default_nettype none

package sgb_pkg;

  localparam int SIGMA      = 15;
  localparam int COORD_W    = 8;
  localparam int MAX_WIDTH  = 1 << COORD_W;
  localparam int MAX_HEIGHT = 1 << COORD_W;
  localparam int DIM_W      = COORD_W + 1;
  localparam int POS_W      = DIM_W + 1;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int FRAME_DEPTH = MAX_WIDTH * MAX_HEIGHT;

  localparam int CH_W   = 8;
  localparam int NCH    = 3;
  localparam int PIX_W  = CH_W * NCH;
  localparam int KIND_W = 2;

  localparam int REACH  = 3 * SIGMA;
  localparam int NTAPS  = 2 * REACH + 1;
  localparam int TAP_W  = $clog2(NTAPS + 1);
  localparam int MAG_W  = $clog2(REACH + 1);

  localparam int ROM_DEPTH = 46;
  localparam int ROM_IDX_W = $clog2(ROM_DEPTH);
  localparam int WT_W      = 5;
  localparam int WSUM_W    = 10;
  localparam int PROD_W    = CH_W + WT_W;
  localparam int ACC_W     = CH_W + WSUM_W;
  localparam int DSH_W     = WSUM_W + CH_W - 1;
  localparam int DCNT_W    = $clog2(CH_W);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_HBLUR = 2'd1,
    KIND_VBLUR = 2'd2
  } kind_t;

  localparam logic [WT_W-1:0] WEIGHT_ROM [0:ROM_DEPTH-1] = '{
    5'd26, 5'd26, 5'd26, 5'd26, 5'd25, 5'd25, 5'd24, 5'd23, 5'd23, 5'd22,
    5'd21, 5'd20, 5'd19, 5'd18, 5'd17, 5'd16, 5'd15, 5'd13, 5'd12, 5'd11,
    5'd10, 5'd9,  5'd9,  5'd8,  5'd7,  5'd6,  5'd5,  5'd5,  5'd4,  5'd4,
    5'd3,  5'd3,  5'd2,  5'd2,  5'd2,  5'd1,  5'd1,  5'd1,  5'd1,  5'd0,
    5'd0,  5'd0,  5'd0,  5'd0,  5'd0,  5'd0
  };

  typedef struct packed {
    logic [NCH-1:0][ACC_W-1:0] acc;
    logic [WSUM_W-1:0]         wsum;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Weight of a tap at distance m from the centre; zero beyond the table.
  function automatic logic [WT_W-1:0] tap_weight(input logic [MAG_W-1:0] m);
    logic [MAG_W+ROM_IDX_W-1:0] mx;
    mx = (MAG_W + ROM_IDX_W)'(m);
    if (mx < (MAG_W + ROM_IDX_W)'(ROM_DEPTH)) begin
      return WEIGHT_ROM[mx[ROM_IDX_W-1:0]];
    end
    return '0;
  endfunction

endpackage

`default_nettype wire

// ----- design/separable_gaussian_blur.sv -----
// Top level of the separable Gaussian blur: frame memory, tap sequencer, accumulators and divider.
//
// Usage: requests arrive on the input channel (in_valid, in_stall, kind, col, row,
// pixel_in). A write request stores pixel_in at (col, row) and gives no result; a
// write outside the configured frame, or a request of unused kind, is dropped.
// A horizontal or vertical blur request gives one result on the output channel
// (out_valid, out_stall, blurred_pixel). A blur inside the frame scans 6*SIGMA+1 taps,
// one frame memory read a cycle through the single read port, then divides each
// channel sum by the weight sum. A blur outside the frame returns 0 without a scan.
// One request is worked on at a time; in_stall is high while a blur is in progress,
// so writes are taken every cycle while no blur is in progress, and a new blur is
// accepted only after the last result has entered the output register. A finished
// result waits in the output register while out_stall is
// high, and the next request is accepted meanwhile. The configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data) sets frame_width (index 0) and
// frame_height (index 1); it is always ready. Reset sets both to 256 and empties the
// output register; the frame memory is not cleared and holds anything until written.
`default_nettype none
`include "separable_gaussian_blur_assert.svh"

module separable_gaussian_blur import sgb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KIND_W-1:0]    kind,
  input  logic [COORD_W-1:0]   col,
  input  logic [COORD_W-1:0]   row,
  input  logic [PIX_W-1:0]     pixel_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PIX_W-1:0]     blurred_pixel
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_TAP   = 6'b000010,
    S_DRAIN = 6'b000100,
    S_START = 6'b001000,
    S_DIV   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t                    state;
  logic [DIM_W-1:0]          frame_width;
  logic [DIM_W-1:0]          frame_height;
  logic [DIM_W-1:0]          lim_w;
  logic [DIM_W-1:0]          lim_h;
  logic [DIM_W-1:0]          lim;
  logic                      in_accept;
  logic                      req_in_frame;
  logic                      vertical;
  logic [COORD_W-1:0]        cen_col;
  logic [COORD_W-1:0]        cen_row;
  logic [COORD_W-1:0]        center;
  logic [TAP_W-1:0]          tap_cnt;
  logic [POS_W-1:0]          pos;
  logic                      tap_in;
  logic [MAG_W-1:0]          mag;
  logic                      tap_hit;
  logic [WT_W-1:0]           tap_wt;
  logic [NCH-1:0][ACC_W-1:0] acc;
  logic [WSUM_W-1:0]         wsum;
  logic [PIX_W-1:0]          res;
  logic                      mem_we;
  logic                      rd_en;
  logic [ADDR_W-1:0]         rd_addr;
  logic [PIX_W-1:0]          rd_data;
  logic [NCH-1:0][CH_W-1:0]  tap_pix;
  logic [NCH-1:0][PROD_W-1:0] prod;
  logic                      out_free;
  div_req_t                  div_req;
  div_stat_t                 div_stat;
  logic [PIX_W-1:0]          div_quot;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign lim_w = (frame_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : frame_width;
  assign lim_h = (frame_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : frame_height;
  assign req_in_frame = (DIM_W'(col) < lim_w) && (DIM_W'(row) < lim_h);

  assign center = vertical ? cen_row : cen_col;
  assign lim    = vertical ? lim_h : lim_w;
  assign pos    = POS_W'(center) + POS_W'(tap_cnt) - POS_W'(REACH);
  assign tap_in = !pos[POS_W-1] && (pos[DIM_W-1:0] < lim);
  assign mag    = (tap_cnt >= TAP_W'(REACH)) ? MAG_W'(tap_cnt - TAP_W'(REACH))
                                             : MAG_W'(TAP_W'(REACH) - tap_cnt);

  assign mem_we  = in_accept && (kind == KIND_WRITE) && req_in_frame;
  assign rd_en   = (state == S_TAP) && tap_in;
  assign rd_addr = vertical ? {pos[COORD_W-1:0], cen_col} : {cen_row, pos[COORD_W-1:0]};
  assign tap_pix = rd_data;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c] = PROD_W'(tap_pix[c]) * PROD_W'(tap_wt);
    end
  end

  sgb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (FRAME_DEPTH)
  ) u_frame (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({row, col}),
    .wdata (pixel_in),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign div_req.acc  = acc;
  assign div_req.wsum = wsum;

  sgb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_START),
    .req   (div_req),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      tap_hit      <= 1'b0;
      frame_width  <= DIM_W'(MAX_WIDTH);
      frame_height <= DIM_W'(MAX_HEIGHT);
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FRAME_WIDTH:  frame_width  <= cfg_data;
          REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
      end
      tap_hit <= rd_en;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_accept && (kind == KIND_HBLUR || kind == KIND_VBLUR)) begin
            state <= req_in_frame ? S_TAP : S_OUT;
          end
        end
        S_TAP: begin
          if (tap_cnt == TAP_W'(NTAPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_START;
        S_START: state <= S_DIV;
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_accept) begin
      vertical <= (kind == KIND_VBLUR);
      cen_col  <= col;
      cen_row  <= row;
      tap_cnt  <= '0;
      acc      <= '0;
      wsum     <= '0;
      res      <= '0;
    end
    if (state == S_TAP) begin
      tap_cnt <= tap_cnt + 1'b1;
    end
    tap_wt <= tap_weight(mag);
    if (tap_hit) begin
      for (int c = 0; c < NCH; c++) begin
        acc[c] <= acc[c] + ACC_W'(prod[c]);
      end
      wsum <= wsum + WSUM_W'(tap_wt);
    end
    if (state == S_DIV && div_stat.done) begin
      res <= div_quot;
    end
    if (state == S_OUT && out_free) begin
      blurred_pixel <= res;
    end
  end

  `SGB_ASSERT(a_div_done_in_div, div_stat.done |-> state == S_DIV, "divider finished outside the divide phase")
  `SGB_ASSERT(a_scan_ends, (state == S_TAP && tap_cnt == TAP_W'(NTAPS - 1)) |=> state == S_DRAIN, "tap scan did not end after the last tap")
  `SGB_ASSERT(a_wsum_nonzero, state == S_START |-> wsum != '0, "weight sum is zero although the centre tap lies in the frame")
  `SGB_ASSERT(a_result_from_out, $rose(out_valid) |-> $past(state == S_OUT), "result presented without passing the output state")

endmodule

`default_nettype wire

// ----- design/sgb_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module sgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- design/sgb_div.sv -----
// Three-lane restoring divider that yields one quotient bit per lane each cycle while busy.
`default_nettype none

module sgb_div import sgb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  div_req_t         req,
  output div_stat_t        stat,
  output logic [PIX_W-1:0] quot
);

  logic                      busy;
  logic                      done;
  logic [DCNT_W-1:0]         cnt;
  logic [NCH-1:0][ACC_W-1:0] rem;
  logic [NCH-1:0][CH_W-1:0]  q;
  logic [DSH_W-1:0]          dsh;
  logic                      zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(CH_W - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= req.acc;
      q    <= '0;
      dsh  <= {req.wsum, (CH_W - 1)'(0)};
      zero <= (req.wsum == '0);
    end else if (busy) begin
      for (int c = 0; c < NCH; c++) begin
        if (rem[c] >= ACC_W'(dsh)) begin
          rem[c] <= rem[c] - ACC_W'(dsh);
          q[c]   <= {q[c][CH_W-2:0], 1'b1};
        end else begin
          q[c]   <= {q[c][CH_W-2:0], 1'b0};
        end
      end
      dsh <= dsh >> 1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = zero ? '0 : q;

endmodule

`default_nettype wire
